// ===== rtl/core/wmse_pkg.sv =====
// Shared constants and types of the weighted MAX-SAT evaluator.
package wmse_pkg;

  localparam int NUM_VARS    = 256;
  localparam int IDX_W       = $clog2(NUM_VARS);
  localparam int ID_W        = 9;
  localparam int W_IN_W      = 16;
  localparam int WEIGHT_BITS = 16;
  localparam int CNT_W       = 13;
  localparam int MAX_CLAUSES = 4096;
  localparam int WS_W        = 24;
  localparam int SQ_W        = 2 * CNT_W;
  localparam int NUM_W       = WS_W + SQ_W;
  localparam int DIV_CNT_W   = $clog2(WS_W + 1);
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 80;
  localparam int OUT_PAD_W   = OUT_DATA_W - (3 * CNT_W + 2 * WS_W + 1 - CNT_W);

  localparam logic KIND_VAR = 1'b0;
  localparam logic KIND_LIT = 1'b1;

  typedef struct packed {
    logic                   en;
    logic [IDX_W-1:0]       addr;
    logic                   val;
    logic [WEIGHT_BITS-1:0] weight;
  } store_wr_t;

endpackage

// ===== rtl/core/wmse_store.sv =====
// Variable store: truth value and weight per variable, with reset-cleared valid bits.
module wmse_store (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [wmse_pkg::IDX_W-1:0]          rd_addr,
  input  wmse_pkg::store_wr_t                 wr,
  output logic                                rd_val,
  output logic [wmse_pkg::WEIGHT_BITS-1:0]    rd_weight
);

  logic [wmse_pkg::WEIGHT_BITS:0] mem [wmse_pkg::NUM_VARS];
  logic [wmse_pkg::WEIGHT_BITS:0] rd_data_r;
  logic [wmse_pkg::NUM_VARS-1:0]  valid_r;
  logic                           rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= {wr.val, wr.weight};
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  // never-written entries read as zero
  assign rd_val    = rd_valid_r & rd_data_r[wmse_pkg::WEIGHT_BITS];
  assign rd_weight = rd_valid_r ? rd_data_r[wmse_pkg::WEIGHT_BITS-1:0] : '0;

endmodule

// ===== rtl/core/wmse_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module wmse_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [wmse_pkg::NUM_W-1:0]    num,
  input  logic [wmse_pkg::SQ_W-1:0]     den,
  output logic                          done,
  output logic [wmse_pkg::WS_W-1:0]     quo
);

  logic [wmse_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;
  logic [wmse_pkg::SQ_W-1:0]      rem_r;
  logic [wmse_pkg::SQ_W-1:0]      den_r;
  logic [wmse_pkg::WS_W-1:0]      low_r;
  logic [wmse_pkg::SQ_W:0]        trial;
  logic [wmse_pkg::SQ_W:0]        diff;
  logic                           ge;

  assign trial = {rem_r, low_r[wmse_pkg::WS_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r  <= wmse_pkg::DIV_CNT_W'(wmse_pkg::WS_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        cnt_r <= cnt_r - wmse_pkg::DIV_CNT_W'(1);
        if (cnt_r == wmse_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // high part of the dividend is below the divisor since the quotient fits WS_W bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[wmse_pkg::NUM_W-1:wmse_pkg::WS_W];
      low_r <= num[wmse_pkg::WS_W-1:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[wmse_pkg::SQ_W-1:0] : trial[wmse_pkg::SQ_W-1:0];
      low_r <= {low_r[wmse_pkg::WS_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = low_r;

endmodule

// ===== rtl/core/weighted_maxsat_evaluator.sv =====
// Top level of the weighted MAX-SAT evaluator: sequencer, counters and shared multiplier.
//
// Input channel (in_*): one item per handshake. in_tuser is the kind: 0 writes a
// variable's truth value and weight, 1 carries one literal of the CNF formula.
// in_tlast marks the formula end; clause_end travels in in_tdata.
// Result channel (out_*): one item per formula end with the satisfied and total
// clause counts, the true-weight sum, the all-satisfied flag and
// floor(weight * sat^2 / clauses^2).
// Sequence: each input item is accepted, then executed on the registered read of the
// variable store. A formula end then runs the shared 26x26 multiplier (sat^2,
// clauses^2, weight * sat^2), starts the bit-serial divider and loads the result
// into the output register.
// in_tready is high only while the sequencer is idle.
// Reset (synchronous, rst_n low) clears all variable values and weights through
// the store's valid bits, the weight total, the clause counters and out_tvalid;
// the block is ready as soon as reset is released.
// A stalled receiver holds the result in the output register; the block keeps
// taking variable and literal items, and only a second formula end waits until
// the held result is taken.
module weighted_maxsat_evaluator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [8:0] var_id, [9] var_value, [25:10] var_weight_in, [26] negated,
  // [27] clause_end, [31:28] zero
  input  logic [wmse_pkg::IN_DATA_W-1:0]       in_tdata,
  // [0] kind
  input  logic                                 in_tuser,
  input  logic                                 in_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [12:0] satisfied_clauses, [25:13] total_clauses, [49:26] weight_sum,
  // [50] all_satisfied, [74:51] penalized_weight, [79:75] zero
  output logic [wmse_pkg::OUT_DATA_W-1:0]      out_tdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_MSQ, S_MTT, S_MWS, S_DIV, S_EMIT
  } state_t;

  localparam int ID_LSB  = 0;
  localparam int VAL_BIT = wmse_pkg::ID_W;
  localparam int W_LSB   = VAL_BIT + 1;
  localparam int NEG_BIT = W_LSB + wmse_pkg::W_IN_W;
  localparam int CE_BIT  = NEG_BIT + 1;

  state_t state_r;

  // item fields captured at accept
  logic                               kind_r;
  logic                               in_range_r;
  logic [wmse_pkg::IDX_W-1:0]         idx_r;
  logic                               val_r;
  logic [wmse_pkg::WEIGHT_BITS-1:0]   weight_r;
  logic                               neg_r;
  logic                               cend_r;
  logic                               fend_r;

  // running state
  logic [wmse_pkg::WS_W-1:0]          total_r;
  logic [wmse_pkg::CNT_W-1:0]         clause_cnt_r;
  logic [wmse_pkg::CNT_W-1:0]         sat_cnt_r;
  logic                               clause_hit_r;

  // result path
  logic [wmse_pkg::CNT_W-1:0]         res_sat_r;
  logic [wmse_pkg::CNT_W-1:0]         res_tot_r;
  logic [wmse_pkg::WS_W-1:0]          res_ws_r;
  logic [wmse_pkg::WS_W-1:0]          pen_r;
  logic [wmse_pkg::SQ_W-1:0]          sq_r;
  logic [wmse_pkg::SQ_W-1:0]          den_r;
  logic [wmse_pkg::NUM_W-1:0]         num_r;
  logic                               div_start_r;
  logic                               out_valid_r;
  logic [wmse_pkg::OUT_DATA_W-1:0]    out_data_r;

  // input decode
  logic [wmse_pkg::ID_W-1:0]          in_id;
  logic [wmse_pkg::ID_W-1:0]          in_id_m1;
  logic                               in_range;
  logic                               in_accept;

  // store
  wmse_pkg::store_wr_t                st_wr;
  logic                               rd_val;
  logic [wmse_pkg::WEIGHT_BITS-1:0]   rd_weight;

  // execute-cycle values
  logic [wmse_pkg::WS_W-1:0]          old_w;
  logic [wmse_pkg::WS_W-1:0]          new_w;
  logic [wmse_pkg::WS_W-1:0]          total_nxt;
  logic                               hit_nxt;
  logic                               close_clause;
  logic [wmse_pkg::CNT_W-1:0]         clause_cnt_nxt;
  logic [wmse_pkg::CNT_W-1:0]         sat_cnt_nxt;

  // shared multiplier
  logic [wmse_pkg::SQ_W-1:0]          mul_a;
  logic [wmse_pkg::SQ_W-1:0]          mul_b;
  logic [2*wmse_pkg::SQ_W-1:0]        mul_p;

  logic                               div_done;
  logic [wmse_pkg::WS_W-1:0]          div_quo;

  function automatic logic [wmse_pkg::CNT_W-1:0] sat_inc(input logic [wmse_pkg::CNT_W-1:0] v);
    logic [wmse_pkg::CNT_W-1:0] r;
    r = (v < wmse_pkg::CNT_W'(wmse_pkg::MAX_CLAUSES)) ? v + wmse_pkg::CNT_W'(1) : v;
    return r;
  endfunction

  // no item is taken while reset is held
  assign in_tready = rst_n && (state_r == S_IDLE);
  assign in_accept = in_tvalid & in_tready;

  assign in_id    = in_tdata[ID_LSB +: wmse_pkg::ID_W];
  assign in_id_m1 = in_id - wmse_pkg::ID_W'(1);
  assign in_range = (in_id != '0) && (in_id <= wmse_pkg::ID_W'(wmse_pkg::NUM_VARS));

  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_r     <= in_tuser;
      in_range_r <= in_range;
      idx_r      <= in_id_m1[wmse_pkg::IDX_W-1:0];
      val_r      <= in_tdata[VAL_BIT];
      weight_r   <= in_tdata[W_LSB +: wmse_pkg::WEIGHT_BITS];
      neg_r      <= in_tdata[NEG_BIT];
      cend_r     <= in_tdata[CE_BIT];
      fend_r     <= in_tlast;
    end
  end

  // store read is issued at accept, data is back in S_EXEC
  wmse_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_addr   (in_id_m1[wmse_pkg::IDX_W-1:0]),
    .wr        (st_wr),
    .rd_val    (rd_val),
    .rd_weight (rd_weight)
  );

  always_comb begin
    st_wr.en     = (state_r == S_EXEC) && (kind_r == wmse_pkg::KIND_VAR) && in_range_r;
    st_wr.addr   = idx_r;
    st_wr.val    = val_r;
    st_wr.weight = weight_r;
  end

  // variable write: drop the old weight if it was true, add the new one if true
  assign old_w     = rd_val ? wmse_pkg::WS_W'(rd_weight) : '0;
  assign new_w     = val_r ? wmse_pkg::WS_W'(weight_r) : '0;
  assign total_nxt = total_r - old_w + new_w;

  // literal: out-of-range variables read as false
  assign hit_nxt        = clause_hit_r | ((in_range_r & rd_val) ^ neg_r);
  assign close_clause   = cend_r | fend_r;
  assign clause_cnt_nxt = close_clause ? sat_inc(clause_cnt_r) : clause_cnt_r;
  assign sat_cnt_nxt    = (close_clause && hit_nxt) ? sat_inc(sat_cnt_r) : sat_cnt_r;

  always_comb begin
    unique case (state_r)
      S_MSQ: begin
        mul_a = wmse_pkg::SQ_W'(res_sat_r);
        mul_b = wmse_pkg::SQ_W'(res_sat_r);
      end
      S_MTT: begin
        mul_a = wmse_pkg::SQ_W'(res_tot_r);
        mul_b = wmse_pkg::SQ_W'(res_tot_r);
      end
      S_MWS: begin
        mul_a = wmse_pkg::SQ_W'(res_ws_r);
        mul_b = sq_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (state_r == S_MSQ) begin
      sq_r <= mul_p[wmse_pkg::SQ_W-1:0];
    end
    if (state_r == S_MTT) begin
      den_r <= mul_p[wmse_pkg::SQ_W-1:0];
    end
    if (state_r == S_MWS) begin
      num_r <= mul_p[wmse_pkg::NUM_W-1:0];
    end
  end

  wmse_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      total_r      <= '0;
      clause_cnt_r <= '0;
      sat_cnt_r    <= '0;
      clause_hit_r <= 1'b0;
      div_start_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      // S_EMIT owns out_valid_r while it loads a new result
      if (out_valid_r && out_tready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (kind_r == wmse_pkg::KIND_VAR) begin
            if (in_range_r) begin
              total_r <= total_nxt;
            end
            state_r <= S_IDLE;
          end else if (fend_r) begin
            res_sat_r    <= sat_cnt_nxt;
            res_tot_r    <= clause_cnt_nxt;
            res_ws_r     <= total_r;
            clause_cnt_r <= '0;
            sat_cnt_r    <= '0;
            clause_hit_r <= 1'b0;
            state_r      <= S_MSQ;
          end else begin
            clause_cnt_r <= clause_cnt_nxt;
            sat_cnt_r    <= sat_cnt_nxt;
            clause_hit_r <= close_clause ? 1'b0 : hit_nxt;
            state_r      <= S_IDLE;
          end
        end
        S_MSQ: state_r <= S_MTT;
        S_MTT: state_r <= S_MWS;
        S_MWS: begin
          div_start_r <= 1'b1;
          state_r     <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            pen_r   <= div_quo;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          // wait for the output register to drain
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {wmse_pkg::OUT_PAD_W'(0), pen_r, (res_sat_r == res_tot_r),
                            res_ws_r, res_tot_r, res_sat_r};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  localparam int PEN_LSB = 2 * wmse_pkg::CNT_W + wmse_pkg::WS_W + 1;
  localparam int WS_LSB  = 2 * wmse_pkg::CNT_W;

  a_sat_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    sat_cnt_r <= clause_cnt_r)
    else $error("satisfied count above clause count");

  a_pen_le_ws: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[PEN_LSB +: wmse_pkg::WS_W] <=
                     out_data_r[WS_LSB +: wmse_pkg::WS_W]))
    else $error("penalized weight above weight sum");

  a_all_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[PEN_LSB-1]) |->
      (out_data_r[PEN_LSB +: wmse_pkg::WS_W] == out_data_r[WS_LSB +: wmse_pkg::WS_W]))
    else $error("all clauses satisfied but weight penalized");

  a_pass_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && kind_r == wmse_pkg::KIND_LIT && fend_r) |=>
      (clause_cnt_r == '0 && sat_cnt_r == '0 && !clause_hit_r))
    else $error("counters not cleared after formula end");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("pending result lost or changed");
`endif

endmodule
